FILE: hw/rtl/cdc_pkg.sv
// types and constants shared by the capacitor dump controller modules
package cdc_pkg;

  localparam int unsigned SampleBits   = 10;
  localparam int unsigned NumButtons   = 4;
  localparam int unsigned HoldBits     = 8;
  localparam int unsigned CfgIndexBits = 3;

  // button bit positions, active-low levels on the input
  localparam int unsigned BtnSave  = 0;
  localparam int unsigned BtnMode  = 1;
  localparam int unsigned BtnPlus  = 2;
  localparam int unsigned BtnMinus = 3;

  localparam logic OpTick   = 1'b0;
  localparam logic OpSample = 1'b1;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgChangeThreshold = 3'd0,
    CfgPressHoldTicks  = 3'd1,
    CfgParallelMax     = 3'd2,
    CfgSeriesMax       = 3'd3,
    CfgMinTicks        = 3'd4
  } cfg_reg_e;

  localparam logic [SampleBits-1:0] ChangeThresholdRst = 10'd11;
  localparam logic [HoldBits-1:0]   PressHoldRst       = 8'd12;
  localparam logic [HoldBits-1:0]   ParallelMaxRst     = 8'd100;
  localparam logic [HoldBits-1:0]   SeriesMaxRst       = 8'd50;
  localparam logic [HoldBits-1:0]   MinTicksRst        = 8'd1;
  localparam logic [HoldBits-1:0]   ParallelHoldRst    = 8'd1;
  localparam logic [HoldBits-1:0]   SeriesHoldRst      = 8'd50;

  typedef struct packed {
    logic                  op;
    logic [NumButtons-1:0] buttons;
    logic [SampleBits-1:0] vcap;
  } in_item_t;

  typedef struct packed {
    logic                  parallel_on;
    logic                  series_on;
    logic                  in_setup;
    logic                  setup_target;
    logic [HoldBits-1:0]   pulse_count;
    logic [HoldBits-1:0]   parallel_hold;
    logic [HoldBits-1:0]   series_hold;
    logic                  save_request;
    logic [NumButtons-1:0] button_events;
  } out_item_t;

  typedef struct packed {
    logic [SampleBits-1:0] change_threshold;
    logic [HoldBits-1:0]   press_hold_ticks;
    logic [HoldBits-1:0]   parallel_max_ticks;
    logic [HoldBits-1:0]   series_max_ticks;
    logic [HoldBits-1:0]   min_ticks;
  } cfg_t;

endpackage

FILE: hw/rtl/cdc_debounce.sv
// button debounce: per-button hold counters, press events and the event latch
module cdc_debounce (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  logic                           tick_i,
  input  logic [cdc_pkg::NumButtons-1:0] buttons_i,
  input  logic [cdc_pkg::HoldBits-1:0]   press_hold_i,
  input  logic                           take_i,
  output logic [cdc_pkg::NumButtons-1:0] made_o,
  output logic [cdc_pkg::NumButtons-1:0] events_o
);

  logic [cdc_pkg::NumButtons-1:0] prev_q, prev_d;
  logic [cdc_pkg::NumButtons-1:0] latch_q, latch_d;
  logic [cdc_pkg::HoldBits-1:0]   cnt_q [cdc_pkg::NumButtons];
  logic [cdc_pkg::HoldBits-1:0]   cnt_d [cdc_pkg::NumButtons];
  logic [cdc_pkg::HoldBits-1:0]   cnt_inc [cdc_pkg::NumButtons];
  logic [cdc_pkg::NumButtons-1:0] latch_upd;

  always_comb begin
    made_o    = '0;
    latch_upd = latch_q;
    for (int i = 0; i < cdc_pkg::NumButtons; i++) begin
      cnt_inc[i] = cnt_q[i] + 1'b1;
      cnt_d[i]   = cnt_q[i];
      if (tick_i) begin
        if (!buttons_i[i] && (prev_q[i] == buttons_i[i])) begin
          cnt_d[i] = cnt_inc[i];
          if (cnt_inc[i] == press_hold_i) begin
            made_o[i]    = 1'b1;
            latch_upd[i] = 1'b1;
            cnt_d[i]     = '0;
          end
        end else begin
          latch_upd[i] = 1'b0;
          cnt_d[i]     = '0;
        end
      end
    end
    events_o = latch_upd;
    latch_d  = take_i ? '0 : latch_upd;
    prev_d   = tick_i ? buttons_i : prev_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      latch_q <= '0;
      for (int i = 0; i < cdc_pkg::NumButtons; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (step_i) begin
      prev_q  <= prev_d;
      latch_q <= latch_d;
      for (int i = 0; i < cdc_pkg::NumButtons; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

endmodule

FILE: hw/rtl/cdc_ctrl.sv
// mode control: reference tracking, hold timing, pulse count and setup adjust
module cdc_ctrl #(
  parameter int unsigned TICK_COUNT_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  cdc_pkg::in_item_t              item_i,
  input  cdc_pkg::cfg_t                  cfg_i,
  input  logic [cdc_pkg::NumButtons-1:0] events_i,
  input  logic [cdc_pkg::NumButtons-1:0] made_i,
  output logic                           take_o,
  output cdc_pkg::out_item_t             res_o
);

  localparam int unsigned CmpBits =
    (TICK_COUNT_BITS > cdc_pkg::HoldBits) ? TICK_COUNT_BITS : cdc_pkg::HoldBits;

  typedef enum logic [1:0] {
    ModeParallel = 2'd0,
    ModeSeries   = 2'd1,
    ModeSetup    = 2'd2
  } mode_e;

  mode_e                             mode_q, mode_d;
  logic                              pending_q, pending_d;
  logic [cdc_pkg::SampleBits-1:0]    ref_q, ref_d;
  logic [TICK_COUNT_BITS-1:0]        tc_q, tc_d, tc_inc;
  logic [cdc_pkg::HoldBits-1:0]      pulses_q, pulses_d;
  logic [cdc_pkg::HoldBits-1:0]      phold_q, phold_d;
  logic [cdc_pkg::HoldBits-1:0]      shold_q, shold_d;
  logic                              tgt_q, tgt_d;
  logic                              is_tick, save;
  logic [CmpBits-1:0]                tc_ext;
  logic                              series_done, parallel_done;
  logic [cdc_pkg::SampleBits-1:0]    diff;

  function automatic logic [cdc_pkg::HoldBits-1:0] adjust(
    input logic [cdc_pkg::HoldBits-1:0] v,
    input logic                         minus,
    input logic                         plus,
    input logic [cdc_pkg::HoldBits-1:0] mn,
    input logic [cdc_pkg::HoldBits-1:0] mx
  );
    logic [cdc_pkg::HoldBits:0] w;
    logic [cdc_pkg::HoldBits:0] mn_w;
    logic [cdc_pkg::HoldBits:0] mx_w;
    w    = {1'b0, v};
    mn_w = {1'b0, mn};
    mx_w = {1'b0, mx};
    if (minus) begin
      if (w >= mn_w + mn_w) w = w - mn_w;
      else                  w = mn_w;
    end
    if (plus) begin
      if (w + mn_w <= mx_w) w = w + mn_w;
      else                  w = mx_w;
    end
    return w[cdc_pkg::HoldBits-1:0];
  endfunction

  always_comb begin
    is_tick = (item_i.op == cdc_pkg::OpTick);
    tc_inc  = (is_tick && (tc_q != '1)) ? tc_q + 1'b1 : tc_q;
    tc_ext  = CmpBits'(tc_inc);
    series_done   = is_tick && (tc_ext >= CmpBits'(shold_q));
    parallel_done = is_tick && !pending_q && (tc_ext >= CmpBits'(phold_q));
    diff = (item_i.vcap > ref_q) ? item_i.vcap - ref_q : ref_q - item_i.vcap;

    mode_d    = mode_q;
    pending_d = pending_q;
    ref_d     = ref_q;
    tc_d      = tc_inc;
    pulses_d  = pulses_q;
    phold_d   = phold_q;
    shold_d   = shold_q;
    tgt_d     = tgt_q;
    save      = 1'b0;
    take_o    = 1'b1;

    unique case (mode_q)
      ModeSeries: begin
        take_o = series_done;
        if (series_done) begin
          if (events_i[cdc_pkg::BtnMode]) begin
            mode_d = ModeSetup;
            tgt_d  = 1'b0;
          end else begin
            mode_d    = ModeParallel;
            pending_d = 1'b1;
            tc_d      = '0;
          end
        end
      end
      ModeSetup: begin
        tgt_d = tgt_q ^ events_i[cdc_pkg::BtnMode];
        if (!tgt_d) begin
          phold_d = adjust(phold_q, events_i[cdc_pkg::BtnMinus], events_i[cdc_pkg::BtnPlus],
                           cfg_i.min_ticks, cfg_i.parallel_max_ticks);
        end else begin
          shold_d = adjust(shold_q, events_i[cdc_pkg::BtnMinus], events_i[cdc_pkg::BtnPlus],
                           cfg_i.min_ticks, cfg_i.series_max_ticks);
        end
        if (events_i[cdc_pkg::BtnSave]) begin
          save      = 1'b1;
          mode_d    = ModeParallel;
          pending_d = 1'b1;
          tc_d      = '0;
        end
      end
      default: begin
        mode_d = ModeParallel;
        if (events_i[cdc_pkg::BtnMode]) begin
          mode_d = ModeSetup;
          tgt_d  = 1'b0;
        end else if (!is_tick) begin
          if (pending_q || (diff >= cfg_i.change_threshold)) begin
            ref_d     = item_i.vcap;
            pending_d = 1'b0;
            tc_d      = '0;
          end
        end else if (parallel_done) begin
          mode_d   = ModeSeries;
          pulses_d = pulses_q + 1'b1;
          tc_d     = '0;
        end
      end
    endcase

    res_o.parallel_on   = (mode_d == ModeParallel);
    res_o.series_on     = (mode_d == ModeSeries);
    res_o.in_setup      = (mode_d == ModeSetup);
    res_o.setup_target  = tgt_d;
    res_o.pulse_count   = pulses_d;
    res_o.parallel_hold = phold_d;
    res_o.series_hold   = shold_d;
    res_o.save_request  = save;
    res_o.button_events = made_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeParallel;
      pending_q <= 1'b1;
      ref_q     <= '0;
      tc_q      <= '0;
      pulses_q  <= '0;
      phold_q   <= cdc_pkg::ParallelHoldRst;
      shold_q   <= cdc_pkg::SeriesHoldRst;
      tgt_q     <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      pending_q <= pending_d;
      ref_q     <= ref_d;
      tc_q      <= tc_d;
      pulses_q  <= pulses_d;
      phold_q   <= phold_d;
      shold_q   <= shold_d;
      tgt_q     <= tgt_d;
    end
  end

endmodule

FILE: hw/rtl/capacitor_dump_controller_core.sv
// top level of the capacitor dump controller: channels, config registers, pipeline
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat is either a 100 Hz
// timer tick carrying the four active-low button levels (op 0) or a capacitor
// voltage sample (op 1). Every input beat gives exactly one output beat on
// out_valid_o / out_stall_i / out_data_o with the switch drives, mode, settings,
// pulse count, save request and the button events made by that beat.
// An input beat waits in the input register, then the control update lands in
// the output register. Throughput is one beat per cycle while the receiver
// does not stall; the only loops are the controller and debounce state updates.
// While the receiver stalls, the output beat holds and one more input beat is
// taken into the input register before in_stall_o rises.
// Config writes (cfg_valid_i / cfg_ready_o) are taken in any cycle; indexes
// beyond the register list are ignored. Writes belong in idle periods.
// Reset puts the block in parallel mode with the reference pending, clears the
// tick count, pulse count and debounce state, and loads the default settings.
module capacitor_dump_controller_core #(
  parameter int unsigned TICK_COUNT_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  cdc_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cdc_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cdc_pkg::CfgIndexBits-1:0]    cfg_index_i,
  input  logic [cdc_pkg::SampleBits-1:0]      cfg_data_i
);

  logic                           in_valid_q, in_valid_d;
  cdc_pkg::in_item_t              in_q;
  logic                           out_valid_q, out_valid_d;
  cdc_pkg::out_item_t             out_q;
  cdc_pkg::out_item_t             res;
  cdc_pkg::cfg_t                  cfg_q;
  logic                           step, in_take, take;
  logic [cdc_pkg::NumButtons-1:0] made, events;

  assign step        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !step;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_take || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && out_stall_i);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  cdc_debounce u_debounce (
    .clk_i,
    .rst_ni,
    .step_i       (step),
    .tick_i       (in_q.op == cdc_pkg::OpTick),
    .buttons_i    (in_q.buttons),
    .press_hold_i (cfg_q.press_hold_ticks),
    .take_i       (take),
    .made_o       (made),
    .events_o     (events)
  );

  cdc_ctrl #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .step_i   (step),
    .item_i   (in_q),
    .cfg_i    (cfg_q),
    .events_i (events),
    .made_i   (made),
    .take_o   (take),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.change_threshold   <= cdc_pkg::ChangeThresholdRst;
      cfg_q.press_hold_ticks   <= cdc_pkg::PressHoldRst;
      cfg_q.parallel_max_ticks <= cdc_pkg::ParallelMaxRst;
      cfg_q.series_max_ticks   <= cdc_pkg::SeriesMaxRst;
      cfg_q.min_ticks          <= cdc_pkg::MinTicksRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cdc_pkg::CfgChangeThreshold: cfg_q.change_threshold <= cfg_data_i;
        cdc_pkg::CfgPressHoldTicks:
          cfg_q.press_hold_ticks <= cfg_data_i[cdc_pkg::HoldBits-1:0];
        cdc_pkg::CfgParallelMax:
          cfg_q.parallel_max_ticks <= cfg_data_i[cdc_pkg::HoldBits-1:0];
        cdc_pkg::CfgSeriesMax:
          cfg_q.series_max_ticks <= cfg_data_i[cdc_pkg::HoldBits-1:0];
        cdc_pkg::CfgMinTicks:
          cfg_q.min_ticks <= cfg_data_i[cdc_pkg::HoldBits-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/cdc_checker.sv
// port-level checks of the capacitor dump controller and their bind
module cdc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input cdc_pkg::out_item_t out_data_o
);

  // a stalled output beat stays and holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed under stall");

  // input backpressure only comes from a full, stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // exactly one mode is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({out_data_o.parallel_on, out_data_o.series_on,
                             out_data_o.in_setup}))
    else $error("mode flags not one-hot");

  // save leaves setup for parallel mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.save_request |-> out_data_o.parallel_on)
    else $error("save request outside parallel mode");

  // the input register is the only path to a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i, 2) || $past(in_stall_o))
    else $error("result without an input beat");

endmodule

bind capacitor_dump_controller_core cdc_checker u_cdc_checker (.*);

FILE: tb/tb_capacitor_dump_controller_core.sv
// testbench for capacitor_dump_controller_core: directed table, random phases, status predictor
`timescale 1ns / 100ps

module tb_capacitor_dump_controller_core;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned NumDirected = 20;
  localparam int unsigned NumPhases   = 6;
  localparam logic [cdc_pkg::HoldBits-1:0] TickMax = 8'hff;

  typedef enum logic [1:0] {
    CtlParallel,
    CtlSeries,
    CtlSetup
  } ctl_mode_e;

  typedef struct packed {
    cdc_pkg::in_item_t  beat;
    logic               typed;
    cdc_pkg::out_item_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             in_valid = 1'b0;
  logic                             in_stall;
  cdc_pkg::in_item_t                in_data = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  cdc_pkg::out_item_t               out_data;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [cdc_pkg::CfgIndexBits-1:0] cfg_index = '0;
  logic [cdc_pkg::SampleBits-1:0]   cfg_data = '0;

  // settings as the block should hold them
  logic [cdc_pkg::SampleBits-1:0] set_threshold = cdc_pkg::ChangeThresholdRst;
  logic [cdc_pkg::HoldBits-1:0]   set_press     = cdc_pkg::PressHoldRst;
  logic [cdc_pkg::HoldBits-1:0]   set_par_max   = cdc_pkg::ParallelMaxRst;
  logic [cdc_pkg::HoldBits-1:0]   set_ser_max   = cdc_pkg::SeriesMaxRst;
  logic [cdc_pkg::HoldBits-1:0]   set_step      = cdc_pkg::MinTicksRst;

  // controller state as predicted
  ctl_mode_e                      ctl_mode     = CtlParallel;
  logic                           awaiting_ref = 1'b1;
  logic [cdc_pkg::SampleBits-1:0] ref_level    = '0;
  logic [cdc_pkg::HoldBits-1:0]   hold_ticks   = '0;
  logic [cdc_pkg::HoldBits-1:0]   dump_count   = '0;
  logic [cdc_pkg::HoldBits-1:0]   par_hold     = cdc_pkg::ParallelHoldRst;
  logic [cdc_pkg::HoldBits-1:0]   ser_hold     = cdc_pkg::SeriesHoldRst;
  logic                           adj_target   = 1'b0;
  logic [cdc_pkg::NumButtons-1:0] last_levels  = '0;
  logic [cdc_pkg::HoldBits-1:0]   press_run [cdc_pkg::NumButtons] = '{default: 8'd0};
  logic [cdc_pkg::NumButtons-1:0] held_events  = '0;

  cdc_pkg::out_item_t awaited_status [$];
  int unsigned        mismatches = 0;
  int unsigned        beats_seen = 0;
  int unsigned        cycles = 0;
  logic               calm = 1'b0;

  // random stimulus shaping
  logic [cdc_pkg::NumButtons-1:0] btn_level = 4'hf;
  int unsigned                    btn_left  = 0;
  int                             vlevel    = 512;

  capacitor_dump_controller_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("tb_capacitor_dump_controller_core: errors");
      $finish;
    end
  end

  function automatic logic [cdc_pkg::HoldBits-1:0] step_setting(
    logic [cdc_pkg::HoldBits-1:0]   cur,
    logic [cdc_pkg::NumButtons-1:0] ev,
    logic [cdc_pkg::HoldBits-1:0]   upper
  );
    int unsigned v;
    int unsigned m;
    v = cur;
    m = set_step;
    if (ev[cdc_pkg::BtnMinus]) v = (v >= m + m) ? v - m : m;
    if (ev[cdc_pkg::BtnPlus]) v = (v + m <= upper) ? v + m : upper;
    return v[cdc_pkg::HoldBits-1:0];
  endfunction

  function automatic cdc_pkg::out_item_t next_switch_status(cdc_pkg::in_item_t b);
    cdc_pkg::out_item_t             s;
    logic [cdc_pkg::NumButtons-1:0] made;
    logic [cdc_pkg::NumButtons-1:0] ev;
    logic                           tick;
    logic                           save;
    logic [cdc_pkg::SampleBits-1:0] vgap;
    tick = (b.op == cdc_pkg::OpTick);
    made = '0;
    ev   = '0;
    save = 1'b0;
    if (tick) begin
      for (int i = 0; i < cdc_pkg::NumButtons; i++) begin
        if (!b.buttons[i] && last_levels[i] == b.buttons[i]) begin
          press_run[i] = press_run[i] + 8'd1;
          if (press_run[i] == set_press) begin
            made[i]        = 1'b1;
            held_events[i] = 1'b1;
            press_run[i]   = '0;
          end
        end else begin
          held_events[i] = 1'b0;
          press_run[i]   = '0;
        end
      end
      last_levels = b.buttons;
      if (hold_ticks != TickMax) hold_ticks = hold_ticks + 8'd1;
    end
    case (ctl_mode)
      CtlSeries: begin
        if (tick && hold_ticks >= ser_hold) begin
          ev = held_events;
          held_events = '0;
          if (ev[cdc_pkg::BtnMode]) begin
            ctl_mode   = CtlSetup;
            adj_target = 1'b0;
          end else begin
            ctl_mode     = CtlParallel;
            awaiting_ref = 1'b1;
            hold_ticks   = '0;
          end
        end
      end
      CtlSetup: begin
        ev = held_events;
        held_events = '0;
        if (ev[cdc_pkg::BtnMode]) adj_target = ~adj_target;
        if (!adj_target) par_hold = step_setting(par_hold, ev, set_par_max);
        else ser_hold = step_setting(ser_hold, ev, set_ser_max);
        if (ev[cdc_pkg::BtnSave]) begin
          save         = 1'b1;
          ctl_mode     = CtlParallel;
          awaiting_ref = 1'b1;
          hold_ticks   = '0;
        end
      end
      default: begin
        ctl_mode = CtlParallel;
        ev = held_events;
        held_events = '0;
        if (ev[cdc_pkg::BtnMode]) begin
          ctl_mode   = CtlSetup;
          adj_target = 1'b0;
        end else if (!tick) begin
          vgap = (b.vcap > ref_level) ? b.vcap - ref_level : ref_level - b.vcap;
          if (awaiting_ref || vgap >= set_threshold) begin
            ref_level    = b.vcap;
            awaiting_ref = 1'b0;
            hold_ticks   = '0;
          end
        end else if (!awaiting_ref && hold_ticks >= par_hold) begin
          ctl_mode   = CtlSeries;
          dump_count = dump_count + 8'd1;
          hold_ticks = '0;
        end
      end
    endcase
    s.parallel_on   = (ctl_mode == CtlParallel);
    s.series_on     = (ctl_mode == CtlSeries);
    s.in_setup      = (ctl_mode == CtlSetup);
    s.setup_target  = adj_target;
    s.pulse_count   = dump_count;
    s.parallel_hold = par_hold;
    s.series_hold   = ser_hold;
    s.save_request  = save;
    s.button_events = made;
    return s;
  endfunction

  // button level runs mostly long enough to make events, plus glitches and short runs
  function automatic cdc_pkg::in_item_t random_beat();
    cdc_pkg::in_item_t b;
    int unsigned       r;
    int unsigned       k;
    int                lvl;
    logic [31:0]       rnd;
    b.op      = cdc_pkg::OpTick;
    rnd       = $urandom;
    b.buttons = rnd[cdc_pkg::NumButtons-1:0];
    rnd       = $urandom;
    b.vcap    = rnd[cdc_pkg::SampleBits-1:0];
    r = $urandom_range(0, 99);
    if (r < 22) begin
      b.op = cdc_pkg::OpSample;
      if ($urandom_range(0, 7) == 0) begin
        vlevel = $urandom_range(0, 1023);
      end else begin
        lvl = vlevel + $urandom_range(0, 16) - 8;
        vlevel = (lvl < 0) ? 0 : (lvl > 1023) ? 1023 : lvl;
      end
      b.vcap = vlevel[cdc_pkg::SampleBits-1:0];
    end else if (r < 92) begin
      if (btn_left == 0) begin
        k = $urandom_range(0, 9);
        if (k < 4) btn_level = 4'hf;
        else if (k < 9) btn_level = ~(4'b0001 << $urandom_range(0, cdc_pkg::NumButtons - 1));
        else begin
          rnd       = $urandom;
          btn_level = rnd[cdc_pkg::NumButtons-1:0];
        end
        k = $urandom_range(0, 5);
        if (k == 0) btn_left = $urandom_range(1, 3);
        else if (k < 5) btn_left = set_press * $urandom_range(1, 3) + 1;
        else btn_left = $urandom_range(1, 300);
      end
      b.buttons = btn_level;
      btn_left  = btn_left - 1;
    end
    return b;
  endfunction

  function automatic dir_row_t directed_row(int unsigned idx);
    dir_row_t r;
    r = '0;
    case (idx)
      0: begin
        r.beat  = '{cdc_pkg::OpSample, 4'hf, 10'd0};
        r.typed = 1'b1;
        r.want  = '{1'b1, 1'b0, 1'b0, 1'b0, 8'd0, cdc_pkg::ParallelHoldRst,
                    cdc_pkg::SeriesHoldRst, 1'b0, 4'h0};
      end
      1:  r.beat = '{cdc_pkg::OpSample, 4'hf, 10'd10};
      2:  r.beat = '{cdc_pkg::OpSample, 4'h0, 10'd1023};
      3:  r.beat = '{cdc_pkg::OpTick, 4'b1101, 10'd0};   // mode right away, enters setup
      4:  r.beat = '{cdc_pkg::OpTick, 4'b1101, 10'd0};   // mode again toggles target
      5:  r.beat = '{cdc_pkg::OpTick, 4'b0111, 10'd1023};
      6:  r.beat = '{cdc_pkg::OpTick, 4'b0111, 10'd0};
      7:  r.beat = '{cdc_pkg::OpTick, 4'b1011, 10'd0};
      8:  r.beat = '{cdc_pkg::OpTick, 4'b1011, 10'd0};   // plus up to the series max
      9:  r.beat = '{cdc_pkg::OpTick, 4'b0011, 10'd0};
      10: r.beat = '{cdc_pkg::OpTick, 4'b0011, 10'd0};
      11: r.beat = '{cdc_pkg::OpTick, 4'b1110, 10'd0};
      12: r.beat = '{cdc_pkg::OpTick, 4'b1110, 10'd0};   // save back to parallel
      13: r.beat = '{cdc_pkg::OpTick, 4'hf, 10'd0};      // no timing while reference pending
      14: r.beat = '{cdc_pkg::OpSample, 4'hf, 10'd512};
      15: r.beat = '{cdc_pkg::OpTick, 4'hf, 10'd0};      // hold reached, series
      16: r.beat = '{cdc_pkg::OpTick, 4'h0, 10'd0};
      17: r.beat = '{cdc_pkg::OpTick, 4'h0, 10'd0};      // all four events
      18: r.beat = '{cdc_pkg::OpSample, 4'h0, 10'd0};
      default: r.beat = '{cdc_pkg::OpTick, 4'hf, 10'd1023};
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string field, int unsigned got, int unsigned want);
    $display("mismatch at beat %0d: %s got %0d want %0d", beats_seen, field, got, want);
    mismatches++;
  endtask

  task automatic check_status(cdc_pkg::out_item_t got, cdc_pkg::out_item_t want);
    if (got.parallel_on !== want.parallel_on)
      note_mismatch("parallel_on", got.parallel_on, want.parallel_on);
    if (got.series_on !== want.series_on)
      note_mismatch("series_on", got.series_on, want.series_on);
    if (got.in_setup !== want.in_setup)
      note_mismatch("in_setup", got.in_setup, want.in_setup);
    if (got.setup_target !== want.setup_target)
      note_mismatch("setup_target", got.setup_target, want.setup_target);
    if (got.pulse_count !== want.pulse_count)
      note_mismatch("pulse_count", got.pulse_count, want.pulse_count);
    if (got.parallel_hold !== want.parallel_hold)
      note_mismatch("parallel_hold", got.parallel_hold, want.parallel_hold);
    if (got.series_hold !== want.series_hold)
      note_mismatch("series_hold", got.series_hold, want.series_hold);
    if (got.save_request !== want.save_request)
      note_mismatch("save_request", got.save_request, want.save_request);
    if (got.button_events !== want.button_events)
      note_mismatch("button_events", got.button_events, want.button_events);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      beats_seen++;
      if (awaited_status.size() == 0) note_mismatch("unexpected beat", 32'(out_data), 0);
      else check_status(out_data, awaited_status.pop_front());
    end
  end

  always @(negedge clk_i) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 38);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_beat(cdc_pkg::in_item_t b, logic typed, cdc_pkg::out_item_t want);
    cdc_pkg::out_item_t predicted;
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predicted = next_switch_status(b);
    awaited_status.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cdc_pkg::cfg_reg_e idx, logic [cdc_pkg::SampleBits-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      cdc_pkg::CfgChangeThreshold: set_threshold = val;
      cdc_pkg::CfgPressHoldTicks:  set_press     = val[cdc_pkg::HoldBits-1:0];
      cdc_pkg::CfgParallelMax:     set_par_max   = val[cdc_pkg::HoldBits-1:0];
      cdc_pkg::CfgSeriesMax:       set_ser_max   = val[cdc_pkg::HoldBits-1:0];
      cdc_pkg::CfgMinTicks:        set_step      = val[cdc_pkg::HoldBits-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_settings(logic [cdc_pkg::SampleBits-1:0] thr,
                                logic [cdc_pkg::HoldBits-1:0] press,
                                logic [cdc_pkg::HoldBits-1:0] pmax,
                                logic [cdc_pkg::HoldBits-1:0] smax,
                                logic [cdc_pkg::HoldBits-1:0] step);
    write_reg(cdc_pkg::CfgChangeThreshold, thr);
    write_reg(cdc_pkg::CfgPressHoldTicks, press);
    write_reg(cdc_pkg::CfgParallelMax, pmax);
    write_reg(cdc_pkg::CfgSeriesMax, smax);
    write_reg(cdc_pkg::CfgMinTicks, step);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // every beat gives a result, so an empty queue plus the pipeline depth means idle
  task automatic drain();
    in_valid <= 1'b0;
    while (awaited_status.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    dir_row_t    row;
    int unsigned count;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    apply_settings(cdc_pkg::ChangeThresholdRst, 8'd1, cdc_pkg::ParallelMaxRst,
                   cdc_pkg::SeriesMaxRst, cdc_pkg::MinTicksRst);
    for (int unsigned i = 0; i < NumDirected; i++) begin
      row = directed_row(i);
      send_beat(row.beat, row.typed, row.want);
    end
    drain();
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin
          apply_settings(cdc_pkg::ChangeThresholdRst, cdc_pkg::PressHoldRst,
                         cdc_pkg::ParallelMaxRst, cdc_pkg::SeriesMaxRst,
                         cdc_pkg::MinTicksRst);
          count = 200;
        end
        1: begin
          apply_settings(10'd1023, 8'd1, 8'd255, 8'd255, 8'd1);
          count = 180;
        end
        2: begin
          apply_settings(10'd40, 8'd3, 8'd10, 8'd5, 8'd2);
          count = 180;
        end
        3: begin
          // lower clamp above the upper clamps
          apply_settings(10'd50, 8'd2, 8'd100, 8'd50, 8'd200);
          count = 150;
        end
        4: begin
          // upper clamps of zero: a plus press drives a hold to zero
          apply_settings(10'd200, 8'd1, 8'd0, 8'd0, 8'd1);
          count = 150;
        end
        default: begin
          apply_settings(10'd1, 8'd255, 8'd255, 8'd255, 8'd255);
          count = 140;
        end
      endcase
      calm = (p == 1);
      for (int unsigned n = 0; n < count; n++) send_beat(random_beat(), 1'b0, '0);
      drain();
    end
    calm = 1'b0;
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && awaited_status.size() == 0) begin
      $display("tb_capacitor_dump_controller_core: clean");
    end else begin
      $display("tb_capacitor_dump_controller_core: errors");
    end
    $finish;
  end

endmodule
